[src/rdc_pkg.sv]
// Shared types, constants and helpers for the radix digit converter.
// No dependencies; used by rdc_divider, rdc_digit_stack and radix_digit_converter.
`timescale 1ns / 1ps

package rdc_pkg;

    localparam int NUM_W      = 31;
    localparam int BASE_W     = 5;
    localparam int DIG_W      = 4;
    localparam int CHAR_W     = 7;
    localparam int BASE_MIN   = 2;
    localparam int BASE_MAX   = 16;
    localparam int DVD_W      = 32;
    localparam int DIV_STEPS  = 8;
    localparam int DIV_CYCLES = DVD_W / DIV_STEPS;
    localparam int DCNT_W     = $clog2(DIV_CYCLES);
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 8;

    localparam logic [CHAR_W-1:0] ASCII_ZERO   = 7'd48;
    localparam logic [CHAR_W-1:0] ASCII_LETTER = 7'd55;
    localparam logic [DIG_W-1:0]  DEC_LIMIT    = 4'd10;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ERR,
        S_DIV,
        S_POP,
        S_LOAD
    } t_state;

    typedef struct packed {
        logic                start;
        logic [NUM_W-1:0]    dividend;
        logic [BASE_W-1:0]   divisor;
    } t_div_req;

    typedef struct packed {
        logic                done;
        logic [NUM_W-1:0]    quo;
        logic [DIG_W-1:0]    rem;
    } t_div_res;

    function automatic logic [CHAR_W-1:0] to_ascii(input logic [DIG_W-1:0] d);
        logic [CHAR_W-1:0] ext;
        ext = {{(CHAR_W-DIG_W){1'b0}}, d};
        if (d < DEC_LIMIT) begin
            return ASCII_ZERO + ext;
        end
        return ASCII_LETTER + ext;
    endfunction

endpackage

[src/rdc_divider.sv]
// Iterative divider of a 31-bit value by a radix, eight quotient bits per cycle.
// Depends on rdc_pkg for widths and the request/result structs.
`timescale 1ns / 1ps

module rdc_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rdc_pkg::t_div_req i_req,
    output rdc_pkg::t_div_res o_res
);

    logic [rdc_pkg::DVD_W-1:0]  r_dvd, n_dvd;
    logic [rdc_pkg::DVD_W-1:0]  r_quo, n_quo;
    logic [rdc_pkg::DIG_W-1:0]  r_rem, n_rem;
    logic [rdc_pkg::BASE_W-1:0] r_div;
    logic [rdc_pkg::DCNT_W-1:0] r_cnt;
    logic                       r_busy;
    logic                       r_done;

    always_comb begin
        logic [rdc_pkg::DIG_W:0] t;
        n_dvd = r_dvd;
        n_quo = r_quo;
        n_rem = r_rem;
        for (int i = 0; i < rdc_pkg::DIV_STEPS; i++) begin
            t     = {n_rem, n_dvd[rdc_pkg::DVD_W-1]};
            n_dvd = {n_dvd[rdc_pkg::DVD_W-2:0], 1'b0};
            if (t >= r_div) begin
                n_rem = rdc_pkg::DIG_W'(t - r_div);
                n_quo = {n_quo[rdc_pkg::DVD_W-2:0], 1'b1};
            end else begin
                n_rem = t[rdc_pkg::DIG_W-1:0];
                n_quo = {n_quo[rdc_pkg::DVD_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == rdc_pkg::DCNT_W'(rdc_pkg::DIV_CYCLES - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd <= {{(rdc_pkg::DVD_W-rdc_pkg::NUM_W){1'b0}}, i_req.dividend};
            r_quo <= '0;
            r_rem <= '0;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_dvd <= n_dvd;
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_res.done = r_done;
    assign o_res.quo  = r_quo[rdc_pkg::NUM_W-1:0];
    assign o_res.rem  = r_rem;

endmodule

[src/rdc_digit_stack.sv]
// Digit stack memory: one write port, one read port with registered read data.
// Depends on rdc_pkg for the digit width.
`timescale 1ns / 1ps

module rdc_digit_stack #(
    parameter int SLOTS = 32
) (
    input  logic                      i_clk,
    input  logic                      i_wr_en,
    input  logic [$clog2(SLOTS)-1:0]  i_wr_addr,
    input  logic [rdc_pkg::DIG_W-1:0] i_wr_data,
    input  logic                      i_rd_en,
    input  logic [$clog2(SLOTS)-1:0]  i_rd_addr,
    output logic [rdc_pkg::DIG_W-1:0] o_rd_data
);

    logic [rdc_pkg::DIG_W-1:0] r_mem [SLOTS];
    logic [rdc_pkg::DIG_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[src/radix_digit_converter.sv]
// Top level of the radix digit converter: control sequencer and output register.
// Depends on rdc_pkg, rdc_divider and rdc_digit_stack.
//
// channel   dir  tdata                            tlast       tuser
// s_axis    in   [30:0] number_in [35:31] base_in -           -
// m_axis    out  [6:0] digit_char                 last_digit  bad_base
//
// A conversion runs one division per digit on the eight-bit-per-cycle divider, then pops
// each digit from the stack memory.
// A radix outside 2 to 16 gives one error request from the error state.
// Reset clears the sequencer, digit count and output valid; the stack needs no clearing.
// A stalled output holds the sequencer in its load or error state; input is taken only
// when idle.
`timescale 1ns / 1ps

module radix_digit_converter #(
    parameter int DIGIT_SLOTS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [rdc_pkg::S_TDATA_W-1:0] i_s_axis_tdata,  // number_in, base_in
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [rdc_pkg::M_TDATA_W-1:0] o_m_axis_tdata,  // digit_char
    output logic                          o_m_axis_tlast,
    output logic                          o_m_axis_tuser   // bad_base
);

    localparam int AW = $clog2(DIGIT_SLOTS);
    localparam int CW = $clog2(DIGIT_SLOTS + 1);

    rdc_pkg::t_state   r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic              r_out_valid, n_out_valid;
    logic [rdc_pkg::CHAR_W-1:0] r_out_char, n_out_char;
    logic              r_out_last, n_out_last;
    logic              r_out_bad, n_out_bad;
    logic [rdc_pkg::BASE_W-1:0] r_base;

    rdc_pkg::t_div_req w_req;
    rdc_pkg::t_div_res w_res;
    logic              w_wr_en;
    logic              w_rd_en;
    logic [AW-1:0]     w_rd_addr;
    logic [rdc_pkg::DIG_W-1:0] w_rd_data;
    logic              w_accept;
    logic              w_out_free;
    logic              w_load;
    logic [rdc_pkg::NUM_W-1:0]  w_number;
    logic [rdc_pkg::BASE_W-1:0] w_base;
    logic              w_bad;
    logic [CW-1:0]     w_count_dec;

    assign w_number    = i_s_axis_tdata[rdc_pkg::NUM_W-1:0];
    assign w_base      = i_s_axis_tdata[rdc_pkg::NUM_W+rdc_pkg::BASE_W-1:rdc_pkg::NUM_W];
    assign w_bad       = (w_base < rdc_pkg::BASE_W'(rdc_pkg::BASE_MIN)) ||
                         (w_base > rdc_pkg::BASE_W'(rdc_pkg::BASE_MAX));
    assign w_accept    = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free  = !r_out_valid || i_m_axis_tready;
    assign w_count_dec = r_count - 1'b1;
    assign w_rd_addr   = w_count_dec[AW-1:0];

    rdc_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_res   (w_res)
    );

    rdc_digit_stack #(
        .SLOTS (DIGIT_SLOTS)
    ) u_stack (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data (w_res.rem),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    always_comb begin
        n_state         = r_state;
        n_count         = r_count;
        n_out_char      = r_out_char;
        n_out_last      = r_out_last;
        n_out_bad       = r_out_bad;
        w_load          = 1'b0;
        w_wr_en         = 1'b0;
        w_rd_en         = 1'b0;
        w_req.start     = 1'b0;
        w_req.dividend  = w_number;
        w_req.divisor   = w_base;
        o_s_axis_tready = 1'b0;
        unique case (r_state)
            rdc_pkg::S_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    n_count = '0;
                    if (w_bad) begin
                        n_state = rdc_pkg::S_ERR;
                    end else begin
                        w_req.start = 1'b1;
                        n_state     = rdc_pkg::S_DIV;
                    end
                end
            end
            rdc_pkg::S_ERR: begin
                if (w_out_free) begin
                    w_load     = 1'b1;
                    n_out_char = '0;
                    n_out_last = 1'b1;
                    n_out_bad  = 1'b1;
                    n_state    = rdc_pkg::S_IDLE;
                end
            end
            rdc_pkg::S_DIV: begin
                w_req.dividend = w_res.quo;
                w_req.divisor  = r_base;
                if (w_res.done) begin
                    if (r_count < CW'(DIGIT_SLOTS)) begin
                        w_wr_en = 1'b1;
                        n_count = r_count + 1'b1;
                    end
                    if (w_res.quo != '0) begin
                        w_req.start = 1'b1;
                    end else begin
                        n_state = rdc_pkg::S_POP;
                    end
                end
            end
            rdc_pkg::S_POP: begin
                w_rd_en = 1'b1;
                n_count = w_count_dec;
                n_state = rdc_pkg::S_LOAD;
            end
            rdc_pkg::S_LOAD: begin
                if (w_out_free) begin
                    w_load     = 1'b1;
                    n_out_char = rdc_pkg::to_ascii(w_rd_data);
                    n_out_last = (r_count == '0);
                    n_out_bad  = 1'b0;
                    n_state    = (r_count == '0) ? rdc_pkg::S_IDLE : rdc_pkg::S_POP;
                end
            end
            default: n_state = rdc_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rdc_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_base <= w_base;
        end
        if (w_load) begin
            r_out_char <= n_out_char;
            r_out_last <= n_out_last;
            r_out_bad  <= n_out_bad;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(rdc_pkg::M_TDATA_W-rdc_pkg::CHAR_W){1'b0}}, r_out_char};
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tuser  = r_out_bad;

    a_bad_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> (o_m_axis_tlast && o_m_axis_tdata == '0))
        else $error("error request without last or with nonzero data");

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rdc_pkg::S_IDLE) |-> (r_count == '0))
        else $error("digit stack not empty while idle");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DIGIT_SLOTS))
        else $error("digit count beyond stack depth");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rdc_pkg::S_POP) |-> (r_count != '0))
        else $error("pop from empty digit stack");

endmodule
